@@ design/bcs_pkg.sv @@
package bcs_pkg;

  // Pump states, shared by the sequencer core and the top level.
  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_BACK  = 4'd1;
  localparam logic [3:0] ST_HOME  = 4'd2;
  localparam logic [3:0] ST_IDLE  = 4'd3;
  localparam logic [3:0] ST_PUSH  = 4'd4;
  localparam logic [3:0] ST_HOLD  = 4'd5;
  localparam logic [3:0] ST_PULL  = 4'd6;
  localparam logic [3:0] ST_SYNC  = 4'd7;
  localparam logic [3:0] ST_ERROR = 4'd8;

  // Drive modes.
  localparam logic [2:0] DRV_OFF      = 3'd0;
  localparam logic [2:0] DRV_REV_6V   = 3'd1;
  localparam logic [2:0] DRV_FWD_6V   = 3'd2;
  localparam logic [2:0] DRV_REV_5V   = 3'd3;
  localparam logic [2:0] DRV_FOLLOW   = 3'd4;

  // Input item functions.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_FORCE = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_HALF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_POS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_POS   = 3'd5;
  localparam int unsigned CFG_DATA_W = 32;

  // Register defaults after reset.
  localparam logic [15:0] RST_PUSH_TICKS = 16'd36;
  localparam logic [15:0] RST_HOLD_TICKS = 16'd12;
  localparam logic [15:0] RST_PULL_HALF  = 16'd36;
  localparam logic signed [31:0] RST_PUSH_POS = 32'sd3212;
  localparam logic signed [31:0] RST_PULL_POS = 32'sd1606;

  typedef struct packed {
    logic [1:0]         func;
    logic               end_switch;
    logic [3:0]         forced_state;
    logic signed [31:0] motor_position;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         state_now;
    logic [2:0]         drive_mode;
    logic               traj_load;
    logic signed [31:0] traj_from;
    logic signed [31:0] traj_to;
    logic [15:0]        traj_duration;
    logic               zero_position;
  } out_item_t;

  // Configuration as seen by the core, positions already fitted and extended.
  typedef struct packed {
    logic               enable;
    logic [15:0]        push_ticks;
    logic [15:0]        hold_ticks;
    logic [15:0]        pull_half_ticks;
    logic signed [31:0] push_position;
    logic signed [31:0] pull_position;
  } cfg_t;

  // Sequencer control state apart from the timer.
  typedef struct packed {
    logic [3:0] state;
    logic       active;
  } ctx_t;

endpackage

@@ design/bcs_if.sv @@
interface bcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               end_switch;
  logic [3:0]         forced_state;
  logic signed [31:0] motor_position;

  modport source (output valid, output func, output end_switch, output forced_state,
                  output motor_position, input ready);
  modport sink (input valid, input func, input end_switch, input forced_state,
                input motor_position, output ready);
endinterface

interface bcs_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         state_now;
  logic [2:0]         drive_mode;
  logic               traj_load;
  logic signed [31:0] traj_from;
  logic signed [31:0] traj_to;
  logic [15:0]        traj_duration;
  logic               zero_position;

  modport source (output valid, output state_now, output drive_mode, output traj_load,
                  output traj_from, output traj_to, output traj_duration,
                  output zero_position, input ready);
  modport sink (input valid, input state_now, input drive_mode, input traj_load,
                input traj_from, input traj_to, input traj_duration,
                input zero_position, output ready);
endinterface

@@ design/breath_cycle_sequencer.sv @@
// Each item passes through the input register, then the result register; with the result
// taken at once, one item completes every cycle. The sustained rate is set by the
// combinational state update in the sequencer core.
// Reset (rst_ni low, asynchronous) puts the pump in init with the trajectory idle and
// its timer at zero, empties both registers, and loads the register defaults.
module breath_cycle_sequencer import bcs_pkg::*; #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned POS_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcs_in_if.sink                in_i,
  bcs_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers; positions are held at the datapath width.
  logic                       enable_q;
  logic [15:0]                push_ticks_q;
  logic [15:0]                hold_ticks_q;
  logic [15:0]                pull_half_q;
  logic signed [POS_BITS-1:0] push_pos_q;
  logic signed [POS_BITS-1:0] pull_pos_q;
  cfg_t                       cfg;

  // Sequencer state.
  ctx_t                       ctx_q, ctx_d;
  logic [TIME_BITS-1:0]       time_q, time_d;

  // Input register and result register.
  logic                       in_valid_q;
  in_item_t                   in_q;
  logic                       out_valid_q;
  out_item_t                  out_q, res_d;
  logic                       advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      push_ticks_q <= RST_PUSH_TICKS;
      hold_ticks_q <= RST_HOLD_TICKS;
      pull_half_q  <= RST_PULL_HALF;
      push_pos_q   <= RST_PUSH_POS[POS_BITS-1:0];
      pull_pos_q   <= RST_PULL_POS[POS_BITS-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        CFG_PUSH_TICKS: push_ticks_q <= cfg_data_i[15:0];
        CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i[15:0];
        CFG_PULL_HALF:  pull_half_q  <= cfg_data_i[15:0];
        CFG_PUSH_POS:   push_pos_q   <= cfg_data_i[POS_BITS-1:0];
        CFG_PULL_POS:   pull_pos_q   <= cfg_data_i[POS_BITS-1:0];
        default:        enable_q     <= enable_q;  // unused index: drop the write
      endcase
    end
  end

  // Positions travel sign-extended to the full field width.
  assign cfg.enable          = enable_q;
  assign cfg.push_ticks      = push_ticks_q;
  assign cfg.hold_ticks      = hold_ticks_q;
  assign cfg.pull_half_ticks = pull_half_q;
  assign cfg.push_position   = 32'(push_pos_q);
  assign cfg.pull_position   = 32'(pull_pos_q);

  // The held item moves into the result register whenever that register is empty
  // or its result is taken in the same cycle. The input register refills in the
  // same cycle it drains, so transfers stream at one per cycle while results are taken.
  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.func           <= in_i.func;
      in_q.end_switch     <= in_i.end_switch;
      in_q.forced_state   <= in_i.forced_state;
      in_q.motor_position <= in_i.motor_position;
    end
  end

  // Sequencer core: one item's full state update in one pass.
  bcs_step #(
    .TIME_BITS(TIME_BITS),
    .POS_BITS (POS_BITS)
  ) u_step (
    .item_i(in_q),
    .cfg_i (cfg),
    .ctx_i (ctx_q),
    .time_i(time_q),
    .ctx_o (ctx_d),
    .time_o(time_d),
    .res_o (res_d)
  );

  // Commit state only when the item actually moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state  <= ST_INIT;
      ctx_q.active <= 1'b0;
      time_q       <= '0;
    end else if (advance) begin
      ctx_q  <= ctx_d;
      time_q <= time_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.state_now     = out_q.state_now;
  assign out_o.drive_mode    = out_q.drive_mode;
  assign out_o.traj_load     = out_q.traj_load;
  assign out_o.traj_from     = out_q.traj_from;
  assign out_o.traj_to       = out_q.traj_to;
  assign out_o.traj_duration = out_q.traj_duration;
  assign out_o.zero_position = out_q.zero_position;

  // A fresh trajectory restarts its timer: zero, or one if a tick advanced it.
  a_load_restarts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.traj_load |=> (time_q == '0 || time_q == 1))
    else $error("trajectory load did not restart the timer");

  // A loaded trajectory is always followed in the same result.
  a_load_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.traj_load |-> out_q.drive_mode == DRV_FOLLOW)
    else $error("trajectory loaded without follow mode");

  // Position zeroing only comes with the end of homing.
  a_zero_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.zero_position |-> out_q.state_now == ST_IDLE && !out_q.traj_load)
    else $error("position zeroed outside home-to-idle");

  // A held item that cannot move on stays held.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled input item lost");

endmodule

@@ design/bcs_step.sv @@
module bcs_step import bcs_pkg::*; #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned POS_BITS  = 32
) (
  input  in_item_t             item_i,
  input  cfg_t                 cfg_i,
  input  ctx_t                 ctx_i,
  input  logic [TIME_BITS-1:0] time_i,
  output ctx_t                 ctx_o,
  output logic [TIME_BITS-1:0] time_o,
  output out_item_t            res_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic signed [POS_BITS-1:0] pos_fit;
  logic signed [31:0]         pos_ext;
  logic [CMP_W-1:0]           t_ext;
  logic [CMP_W-1:0]           push_ext;
  logic [CMP_W-1:0]           hold_ext;
  logic [CMP_W-1:0]           pull_ext;
  logic                       go;
  logic [3:0]                 target;
  logic [3:0]                 ns;
  logic                       na;
  logic [TIME_BITS-1:0]       nt;
  logic                       zero;
  logic                       ld;
  logic signed [31:0]         ld_from;
  logic signed [31:0]         ld_to;
  logic [15:0]                ld_dur;
  logic [2:0]                 mode;

  // Reduce the motor position to the datapath width, then sign-extend.
  assign pos_fit  = item_i.motor_position[POS_BITS-1:0];
  assign pos_ext  = 32'(pos_fit);
  assign t_ext    = CMP_W'(time_i);
  assign push_ext = CMP_W'(cfg_i.push_ticks);
  assign hold_ext = CMP_W'(cfg_i.hold_ticks);
  assign pull_ext = CMP_W'(cfg_i.pull_half_ticks);

  // Pick the requested transition.
  always_comb begin
    go     = 1'b0;
    target = ctx_i.state;
    zero   = 1'b0;
    unique case (item_i.func)
      FUNC_TICK: begin
        if (cfg_i.enable) begin
          if (ctx_i.state == ST_PUSH && t_ext > push_ext) begin
            go = 1'b1; target = ST_HOLD;
          end else if (ctx_i.state == ST_HOLD && t_ext > hold_ext) begin
            go = 1'b1; target = ST_PULL;
          end else if (ctx_i.state == ST_PULL && t_ext > pull_ext) begin
            go = 1'b1; target = ST_SYNC;
          end else if (ctx_i.state == ST_SYNC && t_ext > pull_ext) begin
            go = 1'b1; target = ST_PUSH;
          end else if (ctx_i.state == ST_INIT && item_i.end_switch) begin
            go = 1'b1; target = ST_BACK;
          end else if (ctx_i.state == ST_BACK && !item_i.end_switch) begin
            go = 1'b1; target = ST_HOME;
          end else if (ctx_i.state == ST_HOME && item_i.end_switch) begin
            go = 1'b1; target = ST_IDLE; zero = 1'b1;
          end
        end
      end
      FUNC_START: begin
        go     = cfg_i.enable && (ctx_i.state == ST_IDLE);
        target = ST_PUSH;
      end
      FUNC_STOP: begin
        go     = cfg_i.enable;
        target = ST_INIT;
      end
      FUNC_FORCE: begin
        go     = (item_i.forced_state <= ST_ERROR);
        target = item_i.forced_state;
      end
      default: go = 1'b0;
    endcase
  end

  // Enter the new state, load trajectories, run the timer.
  always_comb begin
    ns      = ctx_i.state;
    na      = ctx_i.active;
    nt      = time_i;
    ld      = 1'b0;
    ld_from = '0;
    ld_to   = '0;
    ld_dur  = '0;
    if (go && target != ctx_i.state) begin
      ns = target;
      case (target)
        ST_PUSH: begin
          ld      = 1'b1;
          ld_from = pos_ext;
          ld_to   = cfg_i.push_position;
          ld_dur  = cfg_i.push_ticks;
        end
        ST_HOLD: begin
          ld      = 1'b1;
          ld_from = cfg_i.push_position;
          ld_to   = cfg_i.push_position;
          ld_dur  = cfg_i.hold_ticks;
        end
        ST_PULL: begin
          ld      = 1'b1;
          ld_from = cfg_i.push_position;
          ld_to   = cfg_i.pull_position;
          ld_dur  = cfg_i.pull_half_ticks;
        end
        ST_SYNC: begin
          ld      = 1'b1;
          ld_from = pos_ext;
          ld_to   = cfg_i.pull_position;
          ld_dur  = cfg_i.pull_half_ticks;
        end
        ST_IDLE: na = 1'b0;
        default: na = ctx_i.active;
      endcase
      if (ld) begin
        nt = '0;
        na = 1'b1;
      end
    end
    if (item_i.func == FUNC_TICK) begin
      if (cfg_i.enable && ns <= ST_IDLE) na = 1'b0;
      if (na && nt != '1) nt = nt + 1'b1;
    end
  end

  always_comb begin
    if (na) begin
      mode = DRV_FOLLOW;
    end else begin
      case (ns)
        ST_INIT: mode = DRV_REV_6V;
        ST_BACK: mode = DRV_FWD_6V;
        ST_HOME: mode = DRV_REV_5V;
        default: mode = DRV_OFF;
      endcase
    end
  end

  assign res_o = '{state_now: ns, drive_mode: mode, traj_load: ld, traj_from: ld_from,
                   traj_to: ld_to, traj_duration: ld_dur, zero_position: zero};
  assign ctx_o.state  = ns;
  assign ctx_o.active = na;
  assign time_o       = nt;

endmodule

@@ sim/breath_cycle_sequencer_test.sv @@
`timescale 1ns / 100ps

module breath_cycle_sequencer_test;
  import bcs_pkg::*;

  // Cycles with no transfer on either side before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;
  // Length of the long receiver hold-off, in cycles.
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  // Cycles to let pass once nothing is outstanding (input and result register).
  localparam int unsigned DRAIN_TAIL = 4;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bcs_in_if  in_if ();
  bcs_out_if out_if ();

  breath_cycle_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted pump: own copy of the registers, the state and the trajectory timer.
  cfg_t        cfg_m;
  logic [3:0]  pump_st;
  logic [15:0] traj_ticks;
  logic        traj_run;

  // Expected status words, oldest first.
  out_item_t   pump_status_q[$];

  int unsigned mismatch_cnt;
  bit          in_gaps_on;
  bit          out_gaps_on;
  bit          hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Move the predicted pump into a new state; a trajectory phase loads its
  // trajectory and restarts the timer. Entering the current state is a no-op.
  function automatic void enter_phase(input logic [3:0] nxt, input logic signed [31:0] pos,
                                      inout out_item_t st);
    if (nxt == pump_st) return;
    case (nxt)
      ST_PUSH, ST_HOLD, ST_PULL, ST_SYNC: begin
        st.traj_load = 1'b1;
        traj_ticks   = '0;
        traj_run     = 1'b1;
        case (nxt)
          ST_PUSH: begin
            st.traj_from     = pos;
            st.traj_to       = cfg_m.push_position;
            st.traj_duration = cfg_m.push_ticks;
          end
          ST_HOLD: begin
            st.traj_from     = cfg_m.push_position;
            st.traj_to       = cfg_m.push_position;
            st.traj_duration = cfg_m.hold_ticks;
          end
          ST_PULL: begin
            st.traj_from     = cfg_m.push_position;
            st.traj_to       = cfg_m.pull_position;
            st.traj_duration = cfg_m.pull_half_ticks;
          end
          default: begin
            st.traj_from     = pos;
            st.traj_to       = cfg_m.pull_position;
            st.traj_duration = cfg_m.pull_half_ticks;
          end
        endcase
      end
      ST_IDLE: traj_run = 1'b0;
      default: ;
    endcase
    pump_st = nxt;
  endfunction

  // Advance the predicted pump by one item and return the status it reports.
  function automatic out_item_t next_pump_status(input in_item_t it);
    out_item_t st;
    st = '0;
    case (it.func)
      FUNC_TICK: begin
        if (cfg_m.enable) begin
          // Compare the timer before it advances.
          if (pump_st == ST_PUSH && traj_ticks > cfg_m.push_ticks)
            enter_phase(ST_HOLD, it.motor_position, st);
          else if (pump_st == ST_HOLD && traj_ticks > cfg_m.hold_ticks)
            enter_phase(ST_PULL, it.motor_position, st);
          else if (pump_st == ST_PULL && traj_ticks > cfg_m.pull_half_ticks)
            enter_phase(ST_SYNC, it.motor_position, st);
          else if (pump_st == ST_SYNC && traj_ticks > cfg_m.pull_half_ticks)
            enter_phase(ST_PUSH, it.motor_position, st);
          else if (pump_st == ST_INIT && it.end_switch)
            enter_phase(ST_BACK, it.motor_position, st);
          else if (pump_st == ST_BACK && !it.end_switch)
            enter_phase(ST_HOME, it.motor_position, st);
          else if (pump_st == ST_HOME && it.end_switch) begin
            enter_phase(ST_IDLE, it.motor_position, st);
            st.zero_position = 1'b1;
          end
          if (pump_st <= ST_IDLE) traj_run = 1'b0;
        end
        // The timer saturates instead of wrapping.
        if (traj_run && traj_ticks != 16'hFFFF) traj_ticks++;
      end
      FUNC_START: if (cfg_m.enable && pump_st == ST_IDLE) enter_phase(ST_PUSH, it.motor_position, st);
      FUNC_STOP:  if (cfg_m.enable) enter_phase(ST_INIT, it.motor_position, st);
      default:    if (it.forced_state <= ST_ERROR) enter_phase(it.forced_state, it.motor_position, st);
    endcase
    if (traj_run)                st.drive_mode = DRV_FOLLOW;
    else if (pump_st == ST_INIT) st.drive_mode = DRV_REV_6V;
    else if (pump_st == ST_BACK) st.drive_mode = DRV_FWD_6V;
    else if (pump_st == ST_HOME) st.drive_mode = DRV_REV_5V;
    else                         st.drive_mode = DRV_OFF;
    st.state_now = pump_st;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < 40)
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one item, hold it until the transfer, then predict its status.
  task automatic send_item(input logic [1:0] fn, input logic sw, input logic [3:0] fst,
                           input logic signed [31:0] pos);
    in_item_t it;
    it = '{func: fn, end_switch: sw, forced_state: fst, motor_position: pos};
    while (in_gaps_on && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= fn;
    in_if.end_switch     <= sw;
    in_if.forced_state   <= fst;
    in_if.motor_position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    pump_status_q.push_back(next_pump_status(it));
  endtask

  task automatic send_tick(input logic sw);
    send_item(FUNC_TICK, sw, 4'($urandom), $urandom);
  endtask

  task automatic send_force(input logic [3:0] fst, input logic signed [31:0] pos);
    send_item(FUNC_FORCE, 1'($urandom), fst, pos);
  endtask

  // Drop valid and wait until every predicted status has been checked.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pump_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Write one register while the block is idle; track it in the prediction.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:     cfg_m.enable          = data[0];
      CFG_PUSH_TICKS: cfg_m.push_ticks      = data[15:0];
      CFG_HOLD_TICKS: cfg_m.hold_ticks      = data[15:0];
      CFG_PULL_HALF:  cfg_m.pull_half_ticks = data[15:0];
      CFG_PUSH_POS:   cfg_m.push_position   = data;
      CFG_PULL_POS:   cfg_m.pull_position   = data;
      default: ;
    endcase
  endtask

  task automatic write_durations(input logic [15:0] push_t, input logic [15:0] hold_t,
                                 input logic [15:0] pull_t);
    write_reg(CFG_PUSH_TICKS, {16'd0, push_t});
    write_reg(CFG_HOLD_TICKS, {16'd0, hold_t});
    write_reg(CFG_PULL_HALF, {16'd0, pull_t});
  endtask

  // Homing with the end switch, a start, one full breathing cycle and a stop.
  task automatic test_homing_and_cycle();
    write_durations(16'd0, 16'd1, 16'd2);
    send_tick(1'b0);                         // init holds without the switch
    send_item(FUNC_START, 1'b0, ST_PUSH, 0); // start outside idle is ignored
    send_tick(1'b1);                         // init -> back
    send_tick(1'b1);
    send_tick(1'b0);                         // back -> home
    send_tick(1'b0);
    send_tick(1'b1);                         // home -> idle, position zeroed
    send_tick(1'b1);
    send_item(FUNC_START, 1'b0, ST_INIT, 32'sd500);
    repeat (11) send_tick(1'($urandom));     // push, hold, pull, sync, push again, hold
    send_item(FUNC_STOP, 1'b0, ST_PUSH, 0);  // trajectory stays live until the tick
    send_tick(1'b0);
  endtask

  // Forcing: the error state, out-of-range codes, same state and the sync, pull and hold loads.
  task automatic test_forced_states();
    send_force(ST_ERROR, 0);
    send_tick(1'b1);                         // the tick leaves error unchanged
    send_force(4'd9, 0);
    send_force(4'hF, 0);
    send_force(ST_ERROR, 0);
    send_force(ST_SYNC, -32'sd77);
    send_force(ST_SYNC, 32'sd5);             // same state, no load
    send_force(ST_PULL, 0);
    send_force(ST_HOLD, 0);
    send_force(ST_BACK, 0);
    send_force(ST_HOME, 0);
    send_force(ST_INIT, 0);
  endtask

  // Disabled: ticks, start and stop do nothing, force still acts, timer runs.
  task automatic test_disabled();
    drain_results();
    write_reg(CFG_ENABLE, 32'd0);
    send_tick(1'b1);
    send_item(FUNC_STOP, 1'b0, ST_IDLE, 0);
    send_force(ST_IDLE, 0);
    send_item(FUNC_START, 1'b0, ST_IDLE, 0);
    send_force(ST_PUSH, 32'sd9);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();
    write_reg(CFG_ENABLE, 32'd1);
    send_tick(1'b0);                         // timer already past zero: push -> hold
  endtask

  // Position extremes and zero durations.
  task automatic test_position_extremes();
    drain_results();
    write_reg(CFG_PUSH_POS, POS_MAX);
    write_reg(CFG_PULL_POS, POS_MIN);
    write_durations(16'd0, 16'd0, 16'd0);
    send_force(ST_IDLE, 0);
    send_item(FUNC_START, 1'b1, ST_ERROR, POS_MIN);
    send_item(FUNC_TICK, 1'b0, 4'd0, POS_MAX);
    repeat (3) send_item(FUNC_TICK, 1'b1, 4'hF, POS_MAX);
    send_item(FUNC_TICK, 1'b0, 4'd0, POS_MIN);
  endtask

  // The longest push duration holds the phase; shortening the duration below
  // the elapsed ticks ends the phase on the next tick.
  task automatic test_long_duration();
    drain_results();
    write_reg(CFG_PUSH_TICKS, 32'hFFFF);
    in_gaps_on = 1'b0;
    send_force(ST_IDLE, 0);
    send_force(ST_PUSH, 0);
    repeat (40) send_tick(1'($urandom));
    drain_results();
    write_reg(CFG_PUSH_TICKS, 32'd30);
    send_tick(1'b0);
    in_gaps_on = 1'b1;
  endtask

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_position();
    case ($urandom_range(5))
      0:       return POS_MAX;
      1:       return POS_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned roll;
    logic [3:0]  fst;
    roll = $urandom_range(99);
    fst  = ($urandom_range(7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (roll < 72)      send_item(FUNC_TICK, 1'($urandom), fst, pick_position());
    else if (roll < 82) send_item(FUNC_START, 1'($urandom), fst, pick_position());
    else if (roll < 88) send_item(FUNC_STOP, 1'($urandom), fst, pick_position());
    else                send_item(FUNC_FORCE, 1'($urandom), fst, pick_position());
  endtask

  // One random phase under a fresh register setting.
  task automatic test_random_phase(input int unsigned n_items, input bit no_gaps,
                                   input bit hold_off, input bit pause);
    drain_results();
    write_reg(CFG_ENABLE, {31'd0, 1'($urandom_range(7) != 0)});
    write_durations(pick_duration(), pick_duration(), pick_duration());
    write_reg(CFG_PUSH_POS, pick_position());
    write_reg(CFG_PULL_POS, pick_position());
    in_gaps_on  = !no_gaps;
    out_gaps_on = !no_gaps;
    // Receiver stalls in its own process; keep offering so the input backs up.
    if (hold_off) hold_off_req = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      // Hold the sender until everything predicted so far has come out.
      if (pause && i == n_items / 2) drain_results();
      send_random_item();
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // Drive ready: random stalls, or a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(out_gaps_on && $urandom_range(99) < 19);
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pump_status_q.size() == 0) begin
        report_mismatch("unexpected result, state_now", out_if.state_now, 0);
      end else begin
        want = pump_status_q.pop_front();
        if (out_if.state_now !== want.state_now)
          report_mismatch("state_now", out_if.state_now, want.state_now);
        if (out_if.drive_mode !== want.drive_mode)
          report_mismatch("drive_mode", out_if.drive_mode, want.drive_mode);
        if (out_if.traj_load !== want.traj_load)
          report_mismatch("traj_load", out_if.traj_load, want.traj_load);
        if (out_if.traj_from !== want.traj_from)
          report_mismatch("traj_from", out_if.traj_from, want.traj_from);
        if (out_if.traj_to !== want.traj_to)
          report_mismatch("traj_to", out_if.traj_to, want.traj_to);
        if (out_if.traj_duration !== want.traj_duration)
          report_mismatch("traj_duration", out_if.traj_duration, want.traj_duration);
        if (out_if.zero_position !== want.zero_position)
          report_mismatch("zero_position", out_if.zero_position, want.zero_position);
      end
    end
  end

  // Abort when neither side has moved for too long.
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("breath_cycle_sequencer test failed");
        $finish;
      end
    end
  end

  initial begin
    // Drive every input to a known value while reset is held.
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_ENABLE;
    cfg_data_i           <= '0;
    in_if.valid          <= 1'b0;
    in_if.func           <= FUNC_TICK;
    in_if.end_switch     <= 1'b0;
    in_if.forced_state   <= ST_INIT;
    in_if.motor_position <= '0;
    mismatch_cnt = 0;
    in_gaps_on   = 1'b1;
    out_gaps_on  = 1'b1;
    hold_off_req = 1'b0;
    cfg_m = '{enable: 1'b1, push_ticks: RST_PUSH_TICKS, hold_ticks: RST_HOLD_TICKS,
              pull_half_ticks: RST_PULL_HALF, push_position: RST_PUSH_POS,
              pull_position: RST_PULL_POS};
    pump_st    = ST_INIT;
    traj_ticks = '0;
    traj_run   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_homing_and_cycle();
    test_forced_states();
    test_disabled();
    test_position_extremes();
    test_long_duration();
    test_random_phase(90, 1'b1, 1'b0, 1'b0);
    test_random_phase(90, 1'b0, 1'b1, 1'b0);
    test_random_phase(90, 1'b0, 1'b0, 1'b1);
    test_random_phase(90, 1'b0, 1'b0, 1'b0);
    test_random_phase(90, 1'b0, 1'b1, 1'b1);

    // Let the last results drain, then give the verdict.
    drain_results();
    if (mismatch_cnt == 0) begin
      $display("breath_cycle_sequencer test passed");
    end else begin
      $display("breath_cycle_sequencer test failed");
    end
    $finish;
  end

endmodule
